FILE: rtl/assert_macros.svh
// Assertion wrappers; empty when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define KPRT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define KPRT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define KPRT_ASSERT(lbl, clk, rst, prop, msg)
`define KPRT_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: rtl/kprt_pkg.sv
package kprt_pkg;

  localparam int TIME_W       = 16;
  localparam int KEYS_W       = 3;
  localparam int NUM_KEYS_DEF = 3;
  localparam int MAX_RESULTS  = 4;

  localparam logic [TIME_W-1:0] QUALIFY_RST  = 16'd50;
  localparam logic [TIME_W-1:0] INIT_DUR_RST = 16'd1;
  localparam logic [TIME_W-1:0] FIRST_RST    = 16'd500;
  localparam logic [TIME_W-1:0] INTERVAL_RST = 16'd100;

  localparam logic [1:0] CFG_QUALIFY  = 2'd0;
  localparam logic [1:0] CFG_INIT_DUR = 2'd1;
  localparam logic [1:0] CFG_FIRST    = 2'd2;
  localparam logic [1:0] CFG_INTERVAL = 2'd3;

  localparam logic [1:0] COMBO_SOURCE = 2'd3;

  typedef enum logic [1:0] {
    PH_OFF      = 2'd0,
    PH_PRESSED  = 2'd1,
    PH_ON       = 2'd2,
    PH_RELEASED = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    TR_PRESSED  = 2'd0,
    TR_REPEAT   = 2'd1,
    TR_RELEASED = 2'd2
  } trans_t;

  typedef struct packed {
    logic [TIME_W-1:0] qualify;
    logic [TIME_W-1:0] init_dur;
    logic [TIME_W-1:0] first;
    logic [TIME_W-1:0] interval;
  } cfg_t;

  typedef struct packed {
    logic              vld;
    trans_t            trans;
    logic [TIME_W-1:0] held;
  } lane_msg_t;

  typedef struct packed {
    logic [1:0]        source;
    trans_t            trans;
    logic [TIME_W-1:0] held;
    logic [KEYS_W-1:0] mask;
    logic              last;
  } out_word_t;

endpackage

FILE: rtl/kprt_key_lane.sv
module kprt_key_lane import kprt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              pressed,
  input  logic [TIME_W-1:0] now,
  input  cfg_t              cfg,
  output lane_msg_t         msg,
  output logic [TIME_W-1:0] dur_upd
);

  logic [TIME_W-1:0] start_time, start_time_next;
  logic [TIME_W-1:0] last_sent, last_sent_next;
  logic [TIME_W-1:0] duration, duration_next;
  phase_t            phase, phase_next;
  lane_msg_t         raw;
  logic [TIME_W-1:0] since_start, since_sent, wait_ms;

  assign since_start = now - start_time;
  assign since_sent  = now - last_sent;
  assign wait_ms     = (phase == PH_PRESSED) ? cfg.first : cfg.interval;

  always_comb begin
    start_time_next = start_time;
    last_sent_next  = last_sent;
    duration_next   = duration;
    phase_next      = phase;
    raw.vld         = 1'b0;
    raw.trans       = TR_PRESSED;
    raw.held        = since_start;
    if (pressed) begin
      if (phase == PH_OFF) begin
        if (duration <= cfg.qualify) begin
          if (duration == '0) begin
            start_time_next = now;
            duration_next   = cfg.init_dur;
          end else begin
            duration_next = since_start;
          end
        end else begin
          phase_next     = PH_PRESSED;
          last_sent_next = now;
          duration_next  = since_start;
          raw.vld        = 1'b1;
        end
      end else if (since_sent > wait_ms) begin
        // released-then-repressed keys land here too, timed from old start
        duration_next  = since_start;
        phase_next     = PH_ON;
        last_sent_next = now;
        raw.vld        = 1'b1;
        raw.trans      = TR_REPEAT;
      end
    end else if (duration != '0) begin
      phase_next    = PH_RELEASED;
      duration_next = '0;
      raw.vld       = 1'b1;
      raw.trans     = TR_RELEASED;
      raw.held      = duration;
    end else begin
      phase_next = PH_OFF;
    end
  end

  always_comb begin
    msg     = raw;
    msg.vld = raw.vld && en;
  end

  assign dur_upd = duration_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_time <= '0;
      last_sent  <= '0;
      duration   <= '0;
      phase      <= PH_OFF;
    end else if (en) begin
      start_time <= start_time_next;
      last_sent  <= last_sent_next;
      duration   <= duration_next;
      phase      <= phase_next;
    end
  end

endmodule

FILE: rtl/kprt_combo_lane.sv
module kprt_combo_lane import kprt_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              multi,
  input  logic [TIME_W-1:0] now,
  input  logic [TIME_W-1:0] common,
  input  cfg_t              cfg,
  output lane_msg_t         msg
);

  logic [TIME_W-1:0] start_time, start_time_next;
  logic [TIME_W-1:0] last_sent, last_sent_next;
  logic [TIME_W-1:0] duration, duration_next;
  phase_t            phase, phase_next;
  logic [TIME_W-1:0] since_sent, wait_ms;
  logic              fire;

  assign since_sent = now - last_sent;
  assign wait_ms    = (phase == PH_PRESSED) ? cfg.first : cfg.interval;

  always_comb begin
    start_time_next = start_time;
    last_sent_next  = last_sent;
    duration_next   = duration;
    phase_next      = phase;
    fire            = 1'b0;
    msg.trans       = TR_PRESSED;
    msg.held        = common;
    if (multi) begin
      if (duration == '0) begin
        // zero init duration re-sends the press on every tick
        start_time_next = now;
        phase_next      = PH_PRESSED;
        duration_next   = cfg.init_dur;
        last_sent_next  = now;
        fire            = 1'b1;
      end else if (since_sent > wait_ms) begin
        duration_next  = now - start_time;
        phase_next     = PH_ON;
        last_sent_next = now;
        fire           = 1'b1;
        msg.trans      = TR_REPEAT;
      end
    end else if (duration != '0) begin
      phase_next    = PH_RELEASED;
      duration_next = '0;
      fire          = 1'b1;
      msg.trans     = TR_RELEASED;
    end else begin
      phase_next = PH_OFF;
    end
    msg.vld = fire && en;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_time <= '0;
      last_sent  <= '0;
      duration   <= '0;
      phase      <= PH_OFF;
    end else if (en) begin
      start_time <= start_time_next;
      last_sent  <= last_sent_next;
      duration   <= duration_next;
      phase      <= phase_next;
    end
  end

endmodule

FILE: rtl/kprt_merge.sv
`include "assert_macros.svh"

module kprt_merge import kprt_pkg::*; #(
  parameter int NUM_KEYS = NUM_KEYS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              capture,
  input  lane_msg_t         slot_msg [NUM_KEYS+1],
  input  logic [KEYS_W-1:0] mask,
  output logic              ready,
  output logic              out_valid,
  input  logic              out_ready,
  output out_word_t         out_word
);

  localparam int N  = NUM_KEYS + 1;
  localparam int IW = $clog2(N);
  localparam int CW = $clog2(N + MAX_RESULTS + 1);

  logic [N-1:0]      bvalid, kept, pick, remaining;
  lane_msg_t         bmsg [N];
  logic [KEYS_W-1:0] bmask;
  logic [IW-1:0]     pick_idx;
  logic [CW-1:0]     cnt;
  logic              move;

  // keep only the first MAX_RESULTS messages of a tick, lane order
  always_comb begin
    cnt = '0;
    for (int i = 0; i < N; i++) begin
      kept[i] = slot_msg[i].vld && (cnt < CW'(MAX_RESULTS));
      if (slot_msg[i].vld) cnt = cnt + 1'b1;
    end
  end

  assign pick      = bvalid & (~bvalid + 1'b1);
  assign remaining = bvalid & ~pick;

  always_comb begin
    pick_idx = '0;
    for (int i = 0; i < N; i++) begin
      if (pick[i]) pick_idx = IW'(i);
    end
  end

  assign move  = (|bvalid) && (!out_valid || out_ready);
  assign ready = !(|bvalid) || (move && !(|remaining));

  always_ff @(posedge clk) begin
    if (rst) begin
      bvalid    <= '0;
      out_valid <= 1'b0;
    end else begin
      if (capture) begin
        bvalid <= kept;
      end else if (move) begin
        bvalid <= remaining;
      end
      if (move) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      for (int i = 0; i < N; i++) bmsg[i] <= slot_msg[i];
      bmask <= mask;
    end
    if (move) begin
      out_word.source <= (pick_idx < IW'(NUM_KEYS)) ? 2'(pick_idx) : COMBO_SOURCE;
      out_word.trans  <= bmsg[pick_idx].trans;
      out_word.held   <= bmsg[pick_idx].held;
      out_word.mask   <= bmask;
      out_word.last   <= !(|remaining);
    end
  end

  `KPRT_ASSERT(a_result_cap, clk, rst, $countones(bvalid) <= MAX_RESULTS, "batch too large")
  `KPRT_ASSERT(a_more_pending, clk, rst, out_valid && !out_word.last |-> |bvalid, "lost word")
  `KPRT_ASSERT(a_capture_kept, clk, rst, capture && (|kept) |=> |bvalid, "batch dropped")
  `KPRT_ASSERT_ALWAYS(a_reset_clear, clk, rst |=> !out_valid && bvalid == '0, "reset")

endmodule

FILE: rtl/key_press_repeat_tracker_core.sv
// Key press / auto-repeat / release tracker. Each input word is one tick:
// a 16-bit millisecond timestamp and a key mask. One lane per key plus a
// combination lane update their state in the cycle the tick is accepted;
// the messages of a tick (up to four, in key order, combination last) are
// then sent one word per cycle, while m_axis_tready does not hold them back,
// through the output register, tlast marking the final one. The next tick
// is taken in the cycle the previous tick's last word moves to the output
// register. Configuration writes are accepted every cycle and should be
// made while no tick is pending.
module key_press_repeat_tracker_core import kprt_pkg::*; #(
  parameter int NUM_KEYS = NUM_KEYS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // now_ms[15:0], keys_down[18:16], zero pad
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // held_ms[15:0], mask[18:16], zero pad
  output logic [3:0]  m_axis_tuser,   // source[1:0], transition[3:2]
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cfg_t              cfg;
  logic              accept, multi, solo;
  logic [TIME_W-1:0] now;
  logic [KEYS_W-1:0] keys, mask;
  logic [NUM_KEYS-1:0] pressed;
  logic [TIME_W-1:0] dur_upd [NUM_KEYS];
  logic [TIME_W-1:0] common;
  lane_msg_t         slot_msg [NUM_KEYS+1];
  out_word_t         out_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.qualify  <= QUALIFY_RST;
      cfg.init_dur <= INIT_DUR_RST;
      cfg.first    <= FIRST_RST;
      cfg.interval <= INTERVAL_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_QUALIFY:  cfg.qualify  <= cfg_data;
        CFG_INIT_DUR: cfg.init_dur <= cfg_data;
        CFG_FIRST:    cfg.first    <= cfg_data;
        CFG_INTERVAL: cfg.interval <= cfg_data;
        default: ;
      endcase
    end
  end

  assign accept = s_axis_tvalid && s_axis_tready;
  assign now    = s_axis_tdata[15:0];
  assign keys   = s_axis_tdata[18:16];

  always_comb begin
    for (int i = 0; i < KEYS_W; i++) mask[i] = keys[i] && (i < NUM_KEYS);
  end

  // two or more keys down hands control to the combination lane
  assign multi = |(mask & (mask - 3'd1));
  assign solo  = !multi;

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    if (k < KEYS_W) begin : g_in
      assign pressed[k] = mask[k];
    end else begin : g_none
      assign pressed[k] = 1'b0;
    end
    kprt_key_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .en      (accept && solo),
      .pressed (pressed[k]),
      .now     (now),
      .cfg     (cfg),
      .msg     (slot_msg[k]),
      .dur_upd (dur_upd[k])
    );
  end

  // at most one key is down when this is nonzero
  always_comb begin
    common = '0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (pressed[k] && solo) common = common | dur_upd[k];
    end
  end

  kprt_combo_lane u_combo (
    .clk    (clk),
    .rst    (rst),
    .en     (accept),
    .multi  (multi),
    .now    (now),
    .common (common),
    .cfg    (cfg),
    .msg    (slot_msg[NUM_KEYS])
  );

  kprt_merge #(.NUM_KEYS(NUM_KEYS)) u_merge (
    .clk       (clk),
    .rst       (rst),
    .capture   (accept),
    .slot_msg  (slot_msg),
    .mask      (mask),
    .ready     (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_word  (out_word)
  );

  assign m_axis_tdata = {5'd0, out_word.mask, out_word.held};
  assign m_axis_tuser = {out_word.trans, out_word.source};
  assign m_axis_tlast = out_word.last;

endmodule

FILE: bench/key_press_repeat_tracker_core_tb.sv
`timescale 1ns / 1ps

module key_press_repeat_tracker_core_tb;
  import kprt_pkg::*;

  localparam int NK         = NUM_KEYS_DEF;
  localparam int CYCLE_CAP  = 1000000;
  localparam int SETTLE     = 8;
  localparam int HOLD_LEN   = 300;

  typedef struct packed {
    logic [TIME_W-1:0] now;
    logic [KEYS_W-1:0] keys;
  } tick_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;    // now_ms[15:0], keys_down[18:16], zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;         // held_ms[15:0], mask[18:16], zero pad
  logic [3:0]  m_axis_tuser;         // source[1:0], transition[3:2]
  logic        m_axis_tlast;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  key_press_repeat_tracker_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // tracker state mirrored in the bench
  logic [TIME_W-1:0] qualify_ms  = QUALIFY_RST;
  logic [TIME_W-1:0] init_dur_ms = INIT_DUR_RST;
  logic [TIME_W-1:0] first_rep_ms = FIRST_RST;
  logic [TIME_W-1:0] interval_ms = INTERVAL_RST;

  logic [TIME_W-1:0] ks_start [NK];
  logic [TIME_W-1:0] ks_last_tx [NK];
  logic [TIME_W-1:0] ks_dur [NK];
  phase_t            ks_phase [NK];
  logic [TIME_W-1:0] combo_start = '0;
  logic [TIME_W-1:0] combo_last_tx = '0;
  logic [TIME_W-1:0] combo_dur = '0;
  phase_t            combo_phase = PH_OFF;

  out_word_t key_msg_q[$];
  tick_t     tick_q[$];
  int        ticks_queued = 0;
  int        ticks_taken = 0;
  int        errors = 0;
  int        cycles = 0;
  int        hold_reqs = 0;
  int        hold_served = 0;
  bit        tx_idle_en = 1'b1;
  bit        rx_idle_en = 1'b1;
  logic [TIME_W-1:0] t_now = '0;

  initial begin
    for (int k = 0; k < NK; k++) begin
      ks_start[k] = '0;
      ks_last_tx[k] = '0;
      ks_dur[k] = '0;
      ks_phase[k] = PH_OFF;
    end
  end

  function automatic logic [TIME_W-1:0] since(logic [TIME_W-1:0] now,
                                               logic [TIME_W-1:0] then_ms);
    return now - then_ms;
  endfunction

  function automatic void post_msg(logic [1:0] src, trans_t tr,
                                   logic [TIME_W-1:0] held, logic [2:0] keys);
    out_word_t w;
    w.source = src;
    w.trans  = tr;
    w.held   = held;
    w.mask   = keys;
    w.last   = 1'b0;
    key_msg_q.push_back(w);
  endfunction

  // expected messages for one tick, appended to key_msg_q
  function automatic void track_tick(logic [TIME_W-1:0] now, logic [2:0] keys);
    int                cnt;
    int                base;
    logic [TIME_W-1:0] common;
    logic [TIME_W-1:0] need_ms;
    cnt    = $countones(keys);
    base   = key_msg_q.size();
    common = '0;
    if (cnt < 2) begin
      for (int k = 0; k < NK; k++) begin
        if (keys[k]) begin
          if (ks_phase[k] == PH_OFF) begin
            if (ks_dur[k] <= qualify_ms) begin
              if (ks_dur[k] == 0) begin
                ks_start[k] = now;
                ks_dur[k] = init_dur_ms;
              end else begin
                ks_dur[k] = since(now, ks_start[k]);
              end
            end else begin
              ks_phase[k] = PH_PRESSED;
              ks_last_tx[k] = now;
              ks_dur[k] = since(now, ks_start[k]);
              post_msg(2'(k), TR_PRESSED, ks_dur[k], keys);
            end
          end else begin
            need_ms = (ks_phase[k] == PH_PRESSED) ? first_rep_ms : interval_ms;
            if (since(now, ks_last_tx[k]) > need_ms) begin
              ks_dur[k] = since(now, ks_start[k]);
              ks_phase[k] = PH_ON;
              ks_last_tx[k] = now;
              post_msg(2'(k), TR_REPEAT, ks_dur[k], keys);
            end
          end
          if (ks_dur[k] > common) common = ks_dur[k];
        end else if (ks_dur[k] > 0) begin
          ks_phase[k] = PH_RELEASED;
          post_msg(2'(k), TR_RELEASED, ks_dur[k], keys);
          ks_dur[k] = '0;
        end else begin
          ks_phase[k] = PH_OFF;
        end
      end
    end
    if (cnt > 1) begin
      if (combo_dur == 0) begin
        combo_start = now;
        combo_phase = PH_PRESSED;
        combo_dur = init_dur_ms;
        combo_last_tx = now;
        post_msg(COMBO_SOURCE, TR_PRESSED, common, keys);
      end else begin
        need_ms = (combo_phase == PH_PRESSED) ? first_rep_ms : interval_ms;
        if (since(now, combo_last_tx) > need_ms) begin
          combo_dur = since(now, combo_start);
          combo_phase = PH_ON;
          combo_last_tx = now;
          post_msg(COMBO_SOURCE, TR_REPEAT, common, keys);
        end
      end
    end else if (combo_dur > 0) begin
      combo_phase = PH_RELEASED;
      post_msg(COMBO_SOURCE, TR_RELEASED, common, keys);
      combo_dur = '0;
    end else begin
      combo_phase = PH_OFF;
    end
    if (key_msg_q.size() > base) key_msg_q[key_msg_q.size()-1].last = 1'b1;
  endfunction

  function automatic int tx_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!tx_idle_en || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // tick driver
  int    tx_gap_left = 0;
  tick_t tx_cur;
  tick_t tx_nxt;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      tx_gap_left <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        track_tick(tx_cur.now, tx_cur.keys);
        ticks_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_gap_left > 0) begin
          tx_gap_left <= tx_gap_left - 1;
          s_axis_tvalid <= 1'b0;
        end else if (tick_q.size() > 0) begin
          tx_nxt = tick_q.pop_front();
          tx_cur <= tx_nxt;
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {5'd0, tx_nxt.keys, tx_nxt.now};
          tx_gap_left <= tx_gap();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver backpressure; a long hold is counted here on request
  int rx_wait = 0;
  int rx_r;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      rx_wait <= 0;
    end else if (rx_wait > 0) begin
      rx_wait <= rx_wait - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_reqs != hold_served) begin
      hold_served <= hold_reqs;
      rx_wait <= HOLD_LEN;
      m_axis_tready <= 1'b0;
    end else begin
      rx_r = $urandom_range(0, 99);
      if (rx_idle_en && rx_r < 20) begin
        rx_wait <= (rx_r < 17) ? $urandom_range(0, 3) : $urandom_range(10, 40);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // message checker
  out_word_t got;
  out_word_t exp_w;

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.source = m_axis_tuser[1:0];
      got.trans  = trans_t'(m_axis_tuser[3:2]);
      got.held   = m_axis_tdata[15:0];
      got.mask   = m_axis_tdata[18:16];
      got.last   = m_axis_tlast;
      if (key_msg_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected word: source %0d trans %0d held %0d mask %0d last %0d",
                   got.source, got.trans, got.held, got.mask, got.last);
      end else begin
        exp_w = key_msg_q.pop_front();
        if (got !== exp_w) begin
          errors++;
          if (errors <= 10)
            $display("mismatch (exp/got): source %0d/%0d trans %0d/%0d held %0d/%0d %s",
                     exp_w.source, got.source, exp_w.trans, got.trans, exp_w.held,
                     got.held, $sformatf("mask %0d/%0d last %0d/%0d",
                     exp_w.mask, got.mask, exp_w.last, got.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic push_tick(logic [TIME_W-1:0] now, logic [2:0] keys);
    tick_t t;
    t.now  = now;
    t.keys = keys;
    tick_q.push_back(t);
    ticks_queued++;
    t_now = now;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_QUALIFY:  qualify_ms = val;
      CFG_INIT_DUR: init_dur_ms = val;
      CFG_FIRST:    first_rep_ms = val;
      CFG_INTERVAL: interval_ms = val;
      default: ;
    endcase
  endtask

  // wait until every tick is taken and every message seen, then let the
  // block go quiet (ticks with no message may still be in flight)
  task automatic settle();
    while (!(ticks_taken == ticks_queued && key_msg_q.size() == 0)) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // episodes of held masks: mostly single keys, some combos and releases,
  // a few short glitches with random masks
  task automatic add_ticks(int n, int step_hi);
    int         cnt;
    int         r;
    int         len;
    logic [2:0] m;
    cnt = 0;
    while (cnt < n) begin
      r = $urandom_range(0, 99);
      len = $urandom_range(1, 20);
      if (r < 55) begin
        m = 3'(1 << $urandom_range(0, NK - 1));
      end else if (r < 70) begin
        m = 3'd0;
        len = $urandom_range(1, 4);
      end else if (r < 92) begin
        case ($urandom_range(0, 3))
          0: m = 3'd3;
          1: m = 3'd5;
          2: m = 3'd6;
          default: m = 3'd7;
        endcase
      end else begin
        m = 3'($urandom_range(0, 7));
        len = $urandom_range(1, 3);
      end
      repeat (len) begin
        if ($urandom_range(0, 99) < 3)
          push_tick(16'($urandom), m);
        else
          push_tick(t_now + 16'($urandom_range(0, step_hi)), m);
        cnt++;
      end
    end
  endtask

  task automatic run_phase(int q, int i, int f, int iv, int step_hi, int n,
                           bit tx_en, bit rx_en, bit long_hold);
    settle();
    write_reg(CFG_QUALIFY, 16'(q));
    write_reg(CFG_INIT_DUR, 16'(i));
    write_reg(CFG_FIRST, 16'(f));
    write_reg(CFG_INTERVAL, 16'(iv));
    tx_idle_en = tx_en;
    rx_idle_en = rx_en;
    if (long_hold) hold_reqs++;
    add_ticks(n, step_hi);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // reset settings: qualify, first repeat, later repeats, release
    push_tick(16'd1000, 3'd1);
    push_tick(16'd1030, 3'd1);
    push_tick(16'd1060, 3'd1);
    push_tick(16'd1061, 3'd1);
    push_tick(16'd1600, 3'd1);
    push_tick(16'd1701, 3'd1);
    push_tick(16'd1702, 3'd0);
    // pressed again right after release: treated as still held
    push_tick(16'd1703, 3'd1);
    push_tick(16'd1900, 3'd1);
    push_tick(16'd1901, 3'd0);
    // released before qualifying
    push_tick(16'd2000, 3'd2);
    push_tick(16'd2001, 3'd0);
    // combination press, repeat, no repeat at exactly the interval, release
    push_tick(16'd3000, 3'd3);
    push_tick(16'd3501, 3'd7);
    push_tick(16'd3601, 3'd6);
    push_tick(16'd3602, 3'd4);
    push_tick(16'd5000, 3'd0);
    // duration collapses to zero on a repeated timestamp
    push_tick(16'd5000, 3'd1);
    push_tick(16'd5000, 3'd1);
    push_tick(16'd5005, 3'd1);
    push_tick(16'd5005, 3'd1);
    push_tick(16'd5006, 3'd0);
    // timestamp wrap while qualifying
    push_tick(16'd65530, 3'd2);
    push_tick(16'd65535, 3'd2);
    push_tick(16'd40, 3'd2);
    push_tick(16'd61, 3'd2);
    add_ticks(60, 40);

    run_phase(3, 2, 10, 4, 6, 70, 1'b1, 1'b1, 1'b0);
    run_phase(0, 1, 0, 0, 3, 60, 1'b1, 1'b1, 1'b0);
    run_phase(65535, 65535, 65535, 65535, 2000, 50, 1'b1, 1'b1, 1'b0);
    // zero initial duration: restarts every tick
    run_phase(5, 0, 8, 3, 5, 70, 1'b1, 1'b1, 1'b0);
    run_phase(20, 7, 40, 15, 12, 70, 1'b0, 1'b0, 1'b1);
    run_phase(1, 1, 2, 1, 2, 60, 1'b0, 1'b1, 1'b0);
    run_phase($urandom_range(0, 40), $urandom_range(0, 10), $urandom_range(0, 60),
              $urandom_range(0, 20), $urandom_range(1, 15), 60, 1'b1, 1'b1, 1'b0);

    settle();
    repeat (20) @(posedge clk);
    errors += key_msg_q.size();
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
